[hdl/xor_distance_kbucket_table_core_macros.svh]
// ----------------------------------------------------------------------------
// xor distance k-bucket table assertion macros
// shared property shapes for the checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef XOR_DISTANCE_KBUCKET_TABLE_CORE_MACROS_SVH
`define XOR_DISTANCE_KBUCKET_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define XDKT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XDKT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/xdkt_pkg.sv]
// ----------------------------------------------------------------------------
// xdkt_pkg
// constants, types and helpers of the xor distance k-bucket table
// ----------------------------------------------------------------------------
package xdkt_pkg;

	localparam int ID_BITS     = 160;
	localparam int BUCKET_SIZE = 8;
	localparam int FIND_LIMIT  = 16;
	localparam int NUM_SLOTS   = ID_BITS * BUCKET_SIZE;
	localparam int ADDR_W      = $clog2(NUM_SLOTS);
	localparam int FILL_W      = $clog2(BUCKET_SIZE + 1);
	localparam int BKT_W       = $clog2(ID_BITS + 1);
	localparam int BIDX_W      = $clog2(ID_BITS);
	localparam int CNT_W       = $clog2(FIND_LIMIT + 1);
	localparam int TOTAL_W     = 11;
	localparam int LZ_STEP     = 8;

	typedef enum logic [0:0] {
		OP_ADD  = 1'b0,
		OP_FIND = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_OWN_HIGH = 2'd0,
		CFG_OWN_MID  = 2'd1,
		CFG_OWN_LOW  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_REFRESHED = 3'd1,
		ST_EVICTED   = 3'd2,
		ST_SELF      = 3'd3,
		ST_NEIGHBOUR = 3'd4,
		ST_NONE      = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_LZC,
		S_FILL,
		S_BKT_RD,
		S_BKT_CMP,
		S_SHF_RD,
		S_SHF_WR,
		S_FRONT,
		S_SFILL,
		S_SCAN,
		S_FRD,
		S_FLOAD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [159:0] key;
		logic [31:0]  address;
		logic [15:0]  port;
		logic [62:0]  seen;
	} entry_t;

	// leading zeros of a byte
	function automatic logic [2:0] lz8(input logic [7:0] v);
		logic [2:0] n;
		logic       hit;
		n   = '0;
		hit = 1'b0;
		for (int k = 7; k >= 0; k--) begin
			if (!hit) begin
				if (v[k]) begin
					hit = 1'b1;
				end else begin
					n = n + 3'd1;
				end
			end
		end
		return n;
	endfunction

endpackage

[hdl/xor_distance_kbucket_table_core.sv]
// ----------------------------------------------------------------------------
// xor_distance_kbucket_table_core
// k-bucket routing table over 160-bit ids: add/refresh by xor bucket,
// find of the closest entries in ascending xor distance
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | in, always ready
//  in      | in_valid/in_ready, operation .. wanted    | in
//  out     | out_valid/out_ready, status .. last       | out
//
//  add: byte-wise leading zero count of the distance, one fill read, a read and
//  compare per bucket slot searched, a read and write per slot moved, a front write
//  find: one scan pass per result, a fill read and a slot walk per bucket, paced
//  by the single read port of each memory, then a read of the best entry per beat
//  one item at a time: in_ready only while idle, the result beat waits
//  for out_ready; after reset a pass over all 160 buckets clears the fill counts first
// ----------------------------------------------------------------------------
module xor_distance_kbucket_table_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         operation,
	input  logic [31:0]  key_high,
	input  logic [63:0]  key_mid,
	input  logic [63:0]  key_low,
	input  logic [31:0]  peer_address,
	input  logic [15:0]  peer_port,
	input  logic [62:0]  seen_time,
	input  logic [4:0]   wanted_count,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [2:0]   status,
	output logic [31:0]  found_high,
	output logic [63:0]  found_mid,
	output logic [63:0]  found_low,
	output logic [31:0]  found_address,
	output logic [15:0]  found_port,
	output logic [62:0]  found_time,
	output logic [10:0]  total_entries,
	output logic         last
);

	localparam int AW = xdkt_pkg::ADDR_W;
	localparam int FW = xdkt_pkg::FILL_W;

	// state and control
	xdkt_pkg::state_t             state_q, state_d;
	logic [159:0]                 own_q;
	logic [xdkt_pkg::BIDX_W-1:0]  clr_q;
	logic [xdkt_pkg::TOTAL_W-1:0] total_q;
	logic                         hit_q, have_prev_q, have_best_q, rv_s1;
	logic [xdkt_pkg::CNT_W-1:0]   want_q, n_q;
	logic [xdkt_pkg::BKT_W-1:0]   b_q;

	// item payload and working registers
	logic [159:0]                 key_q, dist_q, best_d_q, prev_d_q;
	logic [31:0]                  addr_q, hit_addr_q;
	logic [15:0]                  port_q, hit_port_q;
	logic [62:0]                  time_q;
	logic [xdkt_pkg::BKT_W-1:0]   lz_q;
	logic [xdkt_pkg::BIDX_W-1:0]  idx_q;
	logic [AW-1:0]                base_q, ra_s1, best_a_q;
	logic [FW-1:0]                fillc_q, i_q, j_q;

	// result register
	xdkt_pkg::status_t            status_q;
	xdkt_pkg::entry_t             fnd_q;
	logic [xdkt_pkg::TOTAL_W-1:0] tot_q;
	logic                         last_q;

	// entry memory
	xdkt_pkg::entry_t             mem_q [xdkt_pkg::NUM_SLOTS];
	xdkt_pkg::entry_t             rdat_q, wr_d;
	logic                         rd_en, wr_en;
	logic [AW-1:0]                rd_a, wr_a;

	// fill count memory
	logic [FW-1:0]                fill_mem_q [xdkt_pkg::ID_BITS];
	logic [FW-1:0]                frd_q, f_wr_d;
	logic                         f_rd_en, f_wr_en;
	logic [xdkt_pkg::BIDX_W-1:0]  f_rd_a, f_wr_a;

	// combinational helpers
	logic [159:0]                 in_key, in_dist, scan_d;
	logic [10:0]                  want_w1, want_w2;
	logic [xdkt_pkg::BKT_W-1:0]   idx_full;
	logic                         scan_issue, scan_take, scan_done;
	logic [AW-1:0]                scan_a;

	assign in_key   = {key_high, key_mid, key_low};
	assign in_dist  = in_key ^ own_q;
	assign want_w1  = (wanted_count > 5'(xdkt_pkg::FIND_LIMIT)) ?
	                  11'(xdkt_pkg::FIND_LIMIT) : 11'(wanted_count);
	assign want_w2  = (want_w1 > total_q) ? total_q : want_w1;
	assign idx_full = lz_q + xdkt_pkg::BKT_W'(xdkt_pkg::lz8(dist_q[159 -: 8]));

	// scan: issue side walks bucket/slot, compare side sees last cycle's read
	assign scan_issue = (b_q < xdkt_pkg::BKT_W'(xdkt_pkg::ID_BITS)) && (i_q < frd_q);
	assign scan_a     = AW'(AW'(b_q) * AW'(xdkt_pkg::BUCKET_SIZE) + AW'(i_q));
	assign scan_done  = (b_q == xdkt_pkg::BKT_W'(xdkt_pkg::ID_BITS)) && !rv_s1;
	assign scan_d     = rdat_q.key ^ key_q;
	assign scan_take  = rv_s1 && (!have_prev_q || (scan_d > prev_d_q)) &&
	                    (!have_best_q || (scan_d < best_d_q));

	assign cfg_ready     = 1'b1;
	assign out_valid     = (state_q == xdkt_pkg::S_OUT);
	assign status        = status_q;
	assign found_high    = fnd_q.key[159:128];
	assign found_mid     = fnd_q.key[127:64];
	assign found_low     = fnd_q.key[63:0];
	assign found_address = fnd_q.address;
	assign found_port    = fnd_q.port;
	assign found_time    = fnd_q.seen;
	assign total_entries = tot_q;
	assign last          = last_q;

	// next state and memory controls
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_a     = '0;
		wr_en    = 1'b0;
		wr_a     = base_q;
		wr_d     = rdat_q;
		f_rd_en  = 1'b0;
		f_rd_a   = b_q[xdkt_pkg::BIDX_W-1:0];
		f_wr_en  = 1'b0;
		f_wr_a   = idx_q;
		f_wr_d   = '0;
		case (state_q)
			xdkt_pkg::S_CLR: begin
				// one bucket's fill count zeroed per cycle
				f_wr_en = 1'b1;
				f_wr_a  = clr_q;
				if (clr_q == xdkt_pkg::BIDX_W'(xdkt_pkg::ID_BITS - 1)) begin
					state_d = xdkt_pkg::S_IDLE;
				end
			end
			xdkt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == xdkt_pkg::OP_FIND) begin
						state_d = (want_w2 == '0) ? xdkt_pkg::S_OUT : xdkt_pkg::S_SFILL;
					end else begin
						state_d = (in_dist == '0) ? xdkt_pkg::S_OUT : xdkt_pkg::S_LZC;
					end
				end
			end
			xdkt_pkg::S_LZC: begin
				if (dist_q[159 -: 8] != '0) begin
					f_rd_en = 1'b1;
					f_rd_a  = idx_full[xdkt_pkg::BIDX_W-1:0];
					state_d = xdkt_pkg::S_FILL;
				end
			end
			xdkt_pkg::S_FILL: begin
				state_d = xdkt_pkg::S_BKT_RD;
			end
			xdkt_pkg::S_BKT_RD: begin
				if (i_q < fillc_q) begin
					rd_en   = 1'b1;
					rd_a    = AW'(base_q + AW'(i_q));
					state_d = xdkt_pkg::S_BKT_CMP;
				end else begin
					state_d = xdkt_pkg::S_SHF_RD;
				end
			end
			xdkt_pkg::S_BKT_CMP: begin
				state_d = (rdat_q.key == key_q) ? xdkt_pkg::S_SHF_RD : xdkt_pkg::S_BKT_RD;
			end
			xdkt_pkg::S_SHF_RD: begin
				if (j_q == '0) begin
					state_d = xdkt_pkg::S_FRONT;
				end else begin
					rd_en   = 1'b1;
					rd_a    = AW'(base_q + AW'(j_q) - AW'(1));
					state_d = xdkt_pkg::S_SHF_WR;
				end
			end
			xdkt_pkg::S_SHF_WR: begin
				wr_en   = 1'b1;
				wr_a    = AW'(base_q + AW'(j_q));
				state_d = xdkt_pkg::S_SHF_RD;
			end
			xdkt_pkg::S_FRONT: begin
				wr_en        = 1'b1;
				wr_d.key     = key_q;
				wr_d.address = hit_q ? hit_addr_q : addr_q;
				wr_d.port    = hit_q ? hit_port_q : port_q;
				wr_d.seen    = time_q;
				// fresh id into a bucket with room: fill count grows
				f_wr_en      = (status_q == xdkt_pkg::ST_INSERTED);
				f_wr_a       = idx_q;
				f_wr_d       = fillc_q + FW'(1);
				state_d      = xdkt_pkg::S_OUT;
			end
			xdkt_pkg::S_SFILL: begin
				f_rd_en = 1'b1;
				f_rd_a  = b_q[xdkt_pkg::BIDX_W-1:0];
				state_d = xdkt_pkg::S_SCAN;
			end
			xdkt_pkg::S_SCAN: begin
				rd_en = scan_issue;
				rd_a  = scan_a;
				if (scan_done) begin
					state_d = xdkt_pkg::S_FRD;
				end else if (!scan_issue &&
				             (b_q < xdkt_pkg::BKT_W'(xdkt_pkg::ID_BITS - 1))) begin
					state_d = xdkt_pkg::S_SFILL;
				end
			end
			xdkt_pkg::S_FRD: begin
				rd_en   = 1'b1;
				rd_a    = best_a_q;
				state_d = xdkt_pkg::S_FLOAD;
			end
			xdkt_pkg::S_FLOAD: begin
				state_d = xdkt_pkg::S_OUT;
			end
			xdkt_pkg::S_OUT: begin
				if (out_ready) begin
					state_d = last_q ? xdkt_pkg::S_IDLE : xdkt_pkg::S_SFILL;
				end
			end
			default: begin
				state_d = xdkt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xdkt_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, counts and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q       <= '0;
			clr_q       <= '0;
			total_q     <= '0;
			hit_q       <= 1'b0;
			have_prev_q <= 1'b0;
			have_best_q <= 1'b0;
			rv_s1       <= 1'b0;
			want_q      <= '0;
			n_q         <= '0;
			b_q         <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					xdkt_pkg::CFG_OWN_HIGH: own_q[159:128] <= cfg_data[31:0];
					xdkt_pkg::CFG_OWN_MID:  own_q[127:64]  <= cfg_data;
					xdkt_pkg::CFG_OWN_LOW:  own_q[63:0]    <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				xdkt_pkg::S_CLR: begin
					clr_q <= clr_q + xdkt_pkg::BIDX_W'(1);
				end
				xdkt_pkg::S_IDLE: begin
					hit_q       <= 1'b0;
					have_prev_q <= 1'b0;
					have_best_q <= 1'b0;
					rv_s1       <= 1'b0;
					want_q      <= xdkt_pkg::CNT_W'(want_w2);
					n_q         <= '0;
					b_q         <= '0;
				end
				xdkt_pkg::S_BKT_CMP: begin
					if (rdat_q.key == key_q) begin
						hit_q <= 1'b1;
					end
				end
				xdkt_pkg::S_FRONT: begin
					// fresh id into a bucket with room: one more entry
					if (status_q == xdkt_pkg::ST_INSERTED) begin
						total_q <= total_q + xdkt_pkg::TOTAL_W'(1);
					end
				end
				xdkt_pkg::S_SCAN: begin
					rv_s1 <= scan_issue;
					if (b_q < xdkt_pkg::BKT_W'(xdkt_pkg::ID_BITS) && !scan_issue) begin
						b_q <= b_q + xdkt_pkg::BKT_W'(1);
					end
					if (scan_take) begin
						have_best_q <= 1'b1;
					end
				end
				xdkt_pkg::S_FLOAD: begin
					have_prev_q <= 1'b1;
					n_q         <= n_q + xdkt_pkg::CNT_W'(1);
				end
				xdkt_pkg::S_OUT: begin
					// next pass starts from the first bucket
					if (out_ready) begin
						b_q         <= '0;
						have_best_q <= 1'b0;
						rv_s1       <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			xdkt_pkg::S_IDLE: begin
				key_q    <= in_key;
				addr_q   <= peer_address;
				port_q   <= peer_port;
				time_q   <= seen_time;
				dist_q   <= in_dist;
				lz_q     <= '0;
				i_q      <= '0;
				fnd_q    <= '0;
				tot_q    <= total_q;
				last_q   <= 1'b1;
				status_q <= (operation == xdkt_pkg::OP_FIND) ? xdkt_pkg::ST_NONE :
				            xdkt_pkg::ST_SELF;
			end
			xdkt_pkg::S_LZC: begin
				// a whole zero byte per cycle, then the bit count in the top byte
				if (dist_q[159 -: 8] == '0) begin
					dist_q <= dist_q << xdkt_pkg::LZ_STEP;
					lz_q   <= lz_q + xdkt_pkg::BKT_W'(xdkt_pkg::LZ_STEP);
				end else begin
					idx_q   <= idx_full[xdkt_pkg::BIDX_W-1:0];
					base_q  <= AW'(AW'(idx_full) * AW'(xdkt_pkg::BUCKET_SIZE));
					i_q     <= '0;
				end
			end
			xdkt_pkg::S_FILL: begin
				fillc_q <= frd_q;
			end
			xdkt_pkg::S_BKT_RD: begin
				if (i_q >= fillc_q) begin
					// no match: full bucket drops its oldest slot
					if (fillc_q >= FW'(xdkt_pkg::BUCKET_SIZE)) begin
						j_q      <= FW'(xdkt_pkg::BUCKET_SIZE - 1);
						status_q <= xdkt_pkg::ST_EVICTED;
					end else begin
						j_q      <= fillc_q;
						status_q <= xdkt_pkg::ST_INSERTED;
					end
				end
			end
			xdkt_pkg::S_BKT_CMP: begin
				if (rdat_q.key == key_q) begin
					j_q        <= i_q;
					hit_addr_q <= rdat_q.address;
					hit_port_q <= rdat_q.port;
					status_q   <= xdkt_pkg::ST_REFRESHED;
				end else begin
					i_q <= i_q + FW'(1);
				end
			end
			xdkt_pkg::S_SHF_WR: begin
				j_q <= j_q - FW'(1);
			end
			xdkt_pkg::S_FRONT: begin
				tot_q <= (status_q == xdkt_pkg::ST_INSERTED) ?
				         total_q + xdkt_pkg::TOTAL_W'(1) : total_q;
			end
			xdkt_pkg::S_SCAN: begin
				ra_s1 <= scan_a;
				if (scan_issue) begin
					i_q <= i_q + FW'(1);
				end else if (b_q < xdkt_pkg::BKT_W'(xdkt_pkg::ID_BITS)) begin
					i_q <= '0;
				end
				if (scan_take) begin
					best_d_q <= scan_d;
					best_a_q <= ra_s1;
				end
			end
			xdkt_pkg::S_FLOAD: begin
				fnd_q    <= rdat_q;
				status_q <= xdkt_pkg::ST_NEIGHBOUR;
				tot_q    <= total_q;
				last_q   <= ((n_q + xdkt_pkg::CNT_W'(1)) == want_q);
				prev_d_q <= best_d_q;
			end
			xdkt_pkg::S_OUT: begin
				if (out_ready) begin
					i_q <= '0;
				end
			end
			default: ;
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_a] <= wr_d;
		end
		if (rd_en) begin
			rdat_q <= mem_q[rd_a];
		end
	end

	// fill count memory, registered read
	always_ff @(posedge clk) begin
		if (f_wr_en) begin
			fill_mem_q[f_wr_a] <= f_wr_d;
		end
		if (f_rd_en) begin
			frd_q <= fill_mem_q[f_rd_a];
		end
	end

endmodule

[hdl/xdkt_checker.sv]
// ----------------------------------------------------------------------------
// xdkt_checker
// port-level checks of the k-bucket table, bound to the top level
// ----------------------------------------------------------------------------
`include "xor_distance_kbucket_table_core_macros.svh"

module xdkt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [10:0] total_entries,
	input logic        last
);

	`XDKT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(last), "result beat changed while stalled")
	`XDKT_ASSERT_NOW(a_one_item, in_ready, !out_valid, "input taken while a result beat waits")
	`XDKT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second item taken before the first finished")
	`XDKT_ASSERT_NOW(a_single_last, out_valid && (status != xdkt_pkg::ST_NEIGHBOUR), last, "add or empty find result without last")
	`XDKT_ASSERT_NOW(a_total_range, out_valid, total_entries <= 11'(xdkt_pkg::NUM_SLOTS), "entry count beyond table size")

endmodule

bind xor_distance_kbucket_table_core xdkt_checker u_xdkt_checker (.*);
